### sv/sdw_pkg.sv
// Shared constants and opcodes for the session deadline watchdog.
`timescale 1ns / 1ps
package sdw_pkg;
    localparam int SESSION_SLOTS_DEF = 64;
    localparam int TIME_BITS_DEF     = 48;
    localparam int SESS_W            = 6;
    localparam int DUR_W             = 32;
    localparam int OP_W              = 2;
    localparam int WIN_W             = 16;
    localparam logic [WIN_W-1:0] WIN_RESET = 16'd16;

    typedef enum logic [OP_W-1:0] {
        OP_WATCH   = 2'd0,
        OP_UNWATCH = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;
endpackage

### sv/sdw_mem.sv
// Cell memory: one write port, one registered read port.
`timescale 1ns / 1ps
module sdw_mem
    import sdw_pkg::*;
#(
    parameter int SLOTS = SESSION_SLOTS_DEF,
    parameter int TB    = TIME_BITS_DEF,
    localparam int AW   = $clog2(SLOTS),
    localparam int EW   = SESS_W + TB
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [EW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [EW-1:0] rd_data
);
    logic [EW-1:0] mem [SLOTS];
    logic [EW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### sv/sdw_ctrl.sv
// Sequencer: ordered ring of cells kept in memory, insert, remove and expiry pop.
`timescale 1ns / 1ps
module sdw_ctrl
    import sdw_pkg::*;
#(
    parameter int SLOTS = SESSION_SLOTS_DEF,
    parameter int TB    = TIME_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [WIN_W-1:0]  win,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   in_op,
    input  logic [SESS_W-1:0] in_sess,
    input  logic [DUR_W-1:0]  in_dur,
    input  logic [TB-1:0]     in_now,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SESS_W-1:0] out_sess,
    output logic [TB-1:0]     out_dl,
    output logic              out_last
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = SESS_W + TB;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_D_RD  = 13'b0000000000010,
        ST_D_CHK = 13'b0000000000100,
        ST_SD_RD = 13'b0000000001000,
        ST_SD_WR = 13'b0000000010000,
        ST_I_RD  = 13'b0000000100000,
        ST_I_CHK = 13'b0000001000000,
        ST_SU_RD = 13'b0000010000000,
        ST_SU_WR = 13'b0000100000000,
        ST_I_WR  = 13'b0001000000000,
        ST_P_RD  = 13'b0010000000000,
        ST_P_CHK = 13'b0100000000000,
        ST_P_END = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     k_reg, k_next, pos_reg, pos_next, used_reg, used_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [SESS_W-1:0] sess_reg, sess_next;
    logic [TB-1:0]     dl_reg, dl_next;
    logic              pend_reg, pend_next;
    logic [SESS_W-1:0] pend_sess_reg, pend_sess_next;
    logic [TB-1:0]     pend_dl_reg, pend_dl_next;
    logic              ov_reg, ov_next, ol_reg, ol_next;
    logic [SESS_W-1:0] os_reg, os_next;
    logic [TB-1:0]     od_reg, od_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] wr_data, rd_data;
    logic [SESS_W-1:0] rd_sess;
    logic [TB-1:0]     rd_dl, diff, ins_diff;
    logic              due, out_free, sess_ok;
    logic [DUR_W-1:0]  dur_c;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = {1'b0, CW'(h)} + {1'b0, k};
        if (s >= (CW+1)'(SLOTS)) begin
            s = s - (CW+1)'(SLOTS);
        end
        return s[AW-1:0];
    endfunction

    sdw_mem #(.SLOTS(SLOTS), .TB(TB)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_sess  = rd_data[SESS_W-1:0];
    assign rd_dl    = rd_data[EW-1:SESS_W];
    assign diff     = rd_dl - dl_reg;
    assign due      = diff[TB-1] | (diff <= TB'(win));
    assign ins_diff = rd_dl - dl_reg;
    assign out_free = !ov_reg || out_ready;
    assign sess_ok  = 32'(in_sess) < 32'(SLOTS);
    assign dur_c    = (in_dur == '0) ? DUR_W'(1) : in_dur;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        used_next      = used_reg;
        head_next      = head_reg;
        op_next        = op_reg;
        sess_next      = sess_reg;
        dl_next        = dl_reg;
        pend_next      = pend_reg;
        pend_sess_next = pend_sess_reg;
        pend_dl_next   = pend_dl_reg;
        ov_next        = ov_reg && !out_ready;
        os_next        = os_reg;
        od_next        = od_reg;
        ol_next        = ol_reg;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next   = in_op;
                    sess_next = in_sess;
                    k_next    = '0;
                    case (op_t'(in_op))
                        OP_WATCH: begin
                            dl_next = in_now + TB'(dur_c);
                            if (sess_ok) state_next = ST_D_RD;
                        end
                        OP_UNWATCH: begin
                            if (sess_ok) state_next = ST_D_RD;
                        end
                        OP_TICK: begin
                            dl_next    = in_now;
                            state_next = ST_P_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_D_RD: begin
                if (k_reg == used_reg) begin
                    k_next     = '0;
                    state_next = (op_t'(op_reg) == OP_WATCH) ? ST_I_RD : ST_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = phys(head_reg, k_reg);
                    state_next = ST_D_CHK;
                end
            end
            ST_D_CHK: begin
                if (rd_sess == sess_reg) begin
                    state_next = ST_SD_RD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_D_RD;
                end
            end
            ST_SD_RD: begin
                if (k_reg + 1'b1 == used_reg) begin
                    used_next  = used_reg - 1'b1;
                    k_next     = '0;
                    state_next = (op_t'(op_reg) == OP_WATCH) ? ST_I_RD : ST_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = phys(head_reg, k_reg + 1'b1);
                    state_next = ST_SD_WR;
                end
            end
            ST_SD_WR: begin
                wr_en      = 1'b1;
                wr_addr    = phys(head_reg, k_reg);
                k_next     = k_reg + 1'b1;
                state_next = ST_SD_RD;
            end
            ST_I_RD: begin
                if (used_reg == CW'(SLOTS)) begin
                    state_next = ST_IDLE;
                end else if (k_reg == used_reg) begin
                    pos_next   = k_reg;
                    state_next = ST_SU_RD;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = phys(head_reg, k_reg);
                    state_next = ST_I_CHK;
                end
            end
            ST_I_CHK: begin
                if (!ins_diff[TB-1]) begin
                    pos_next   = k_reg;
                    k_next     = used_reg;
                    state_next = ST_SU_RD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_I_RD;
                end
            end
            ST_SU_RD: begin
                if (k_reg == pos_reg) begin
                    state_next = ST_I_WR;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = phys(head_reg, k_reg - 1'b1);
                    state_next = ST_SU_WR;
                end
            end
            ST_SU_WR: begin
                wr_en      = 1'b1;
                wr_addr    = phys(head_reg, k_reg);
                k_next     = k_reg - 1'b1;
                state_next = ST_SU_RD;
            end
            ST_I_WR: begin
                wr_en      = 1'b1;
                wr_addr    = phys(head_reg, pos_reg);
                wr_data    = {dl_reg, sess_reg};
                used_next  = used_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_P_RD: begin
                if (used_reg == '0) begin
                    state_next = ST_P_END;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = ST_P_CHK;
                end
            end
            ST_P_CHK: begin
                if (!due) begin
                    state_next = ST_P_END;
                end else if (!pend_reg || out_free) begin
                    if (pend_reg) begin
                        ov_next = 1'b1;
                        os_next = pend_sess_reg;
                        od_next = pend_dl_reg;
                        ol_next = 1'b0;
                    end
                    pend_next      = 1'b1;
                    pend_sess_next = rd_sess;
                    pend_dl_next   = rd_dl;
                    head_next      = phys(head_reg, CW'(1));
                    used_next      = used_reg - 1'b1;
                    state_next     = ST_P_RD;
                end
            end
            ST_P_END: begin
                if (!pend_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    ov_next    = 1'b1;
                    os_next    = pend_sess_reg;
                    od_next    = pend_dl_reg;
                    ol_next    = 1'b1;
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            head_reg  <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
        k_reg         <= k_next;
        pos_reg       <= pos_next;
        op_reg        <= op_next;
        sess_reg      <= sess_next;
        dl_reg        <= dl_next;
        pend_sess_reg <= pend_sess_next;
        pend_dl_reg   <= pend_dl_next;
        os_reg        <= os_next;
        od_reg        <= od_next;
        ol_reg        <= ol_next;
    end

    assign out_valid = ov_reg;
    assign out_sess  = os_reg;
    assign out_dl    = od_reg;
    assign out_last  = ol_reg;
endmodule

### sv/session_deadline_watchdog_unit.sv
// Top level: session deadline watchdog with register port and item streams.
//
//  channel  | direction | ports
//  s_       | in        | s_tvalid s_tready s_tdata s_tuser  (watch / unwatch / tick)
//  m_       | out       | m_tvalid m_tready m_tdata m_tlast  (expired sessions)
//  APB      | in        | psel penable pwrite paddr pwdata prdata pready
//
// Watch: scan the held cells to drop the session, then scan and shift to insert.
// Unwatch: scan the held cells to drop the session. Tick: pop each due cell from the head.
// Cost is set by the separate read and write steps of the cell memory.
// Reset (aresetn low, synchronous) empties the list; no clearing pass.
// A result waits in the output register; a stalled m_ side halts the tick.
`timescale 1ns / 1ps
module session_deadline_watchdog_unit
    import sdw_pkg::*;
#(
    parameter int SESSION_SLOTS = SESSION_SLOTS_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF,
    localparam int IN_W  = ((SESS_W + DUR_W + TIME_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((SESS_W + TIME_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // session_index, duration_ms, now_ms
    input  logic [OP_W-1:0]  s_tuser,   // opcode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // expired_session, expired_deadline
    output logic             m_tlast,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [WIN_W-1:0]     win_reg;
    logic [SESS_W-1:0]    out_sess;
    logic [TIME_BITS-1:0] out_dl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WIN_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            win_reg <= pwdata[WIN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(win_reg);

    sdw_ctrl #(.SLOTS(SESSION_SLOTS), .TB(TIME_BITS)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .win       (win_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_sess   (s_tdata[SESS_W-1:0]),
        .in_dur    (s_tdata[SESS_W+DUR_W-1:SESS_W]),
        .in_now    (s_tdata[SESS_W+DUR_W+TIME_BITS-1:SESS_W+DUR_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sess  (out_sess),
        .out_dl    (out_dl),
        .out_last  (m_tlast)
    );

    assign m_tdata = OUT_W'({out_dl, out_sess});
endmodule
